FILE: sv/pcsp_pkg.sv
// Shared types and codes for the pixel command stream parser.
package pcsp_pkg;

  // Command kinds as carried by the kind byte; idle means awaiting a kind byte.
  localparam logic [2:0] KIND_IDLE   = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_PIXEL  = 3'd2;
  localparam logic [2:0] KIND_RECT   = 3'd3;
  localparam logic [2:0] KIND_CONTIG = 3'd4;

  // Result operation codes.
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_RECT  = 2'd2;
  localparam logic [1:0] OP_ERROR = 2'd3;

  // Byte positions within a command header.
  localparam logic [2:0] POS_X      = 3'd0;
  localparam logic [2:0] POS_Y      = 3'd1;
  localparam logic [2:0] POS_WIDTH  = 3'd2;
  localparam logic [2:0] POS_HEIGHT = 3'd3;
  localparam logic [2:0] POS_PIXEL  = 3'd4;

  // Color byte indexes within a color triple.
  localparam logic [2:0] COLOUR_RED   = 3'd0;
  localparam logic [2:0] COLOUR_GREEN = 3'd1;

  // One drawing command result.
  typedef struct packed {
    logic [1:0] op;
    logic [8:0] pos_x;
    logic [8:0] pos_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       command_done;
  } pcsp_result_t;

endpackage

FILE: sv/pcsp_decode.sv
// Parser state and per-byte decode that forms one drawing command result.
module pcsp_decode
  import pcsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  output logic         has_result,
  output pcsp_result_t result
);

  logic [2:0] kind, kind_next;
  logic [2:0] pos, pos_next;
  logic [7:0] start_x, start_x_next;
  logic [7:0] start_y, start_y_next;
  logic [7:0] held_width, held_width_next;
  logic [7:0] held_height, held_height_next;
  logic [7:0] held_red, held_red_next;
  logic [7:0] held_green, held_green_next;
  logic [7:0] column_count, column_count_next;
  logic [7:0] row_count, row_count_next;

  logic [2:0] colour_index;
  logic [8:0] column_plus;
  logic [8:0] row_plus;
  logic       last_col;
  logic       last_pixel;
  logic       kind_valid;

  // Index of the current byte within its color triple.
  always_comb begin
    unique case (kind)
      KIND_FILL:  colour_index = pos;
      KIND_PIXEL: colour_index = pos - POS_WIDTH;
      default:    colour_index = pos - POS_PIXEL;
    endcase
  end

  // Position tracking inside a contiguous rectangle.
  assign column_plus = {1'b0, column_count} + 9'd1;
  assign row_plus    = {1'b0, row_count} + 9'd1;
  assign last_col    = column_plus >= {1'b0, held_width};
  assign last_pixel  = last_col && (row_plus >= {1'b0, held_height});
  assign kind_valid  = (data_byte >= {5'd0, KIND_FILL}) && (data_byte <= {5'd0, KIND_CONTIG});

  // Next state and result for the byte at hand.
  always_comb begin
    kind_next         = kind;
    pos_next          = pos;
    start_x_next      = start_x;
    start_y_next      = start_y;
    held_width_next   = held_width;
    held_height_next  = held_height;
    held_red_next     = held_red;
    held_green_next   = held_green;
    column_count_next = column_count;
    row_count_next    = row_count;
    has_result        = 1'b0;
    result            = '0;
    result.red        = held_red;
    result.green      = held_green;
    result.blue       = data_byte;
    result.command_done = 1'b1;

    if (kind == KIND_IDLE) begin
      if (kind_valid) begin
        kind_next         = data_byte[2:0];
        pos_next          = POS_X;
        column_count_next = '0;
        row_count_next    = '0;
      end else begin
        has_result      = 1'b1;
        held_red_next   = '0;
        held_green_next = '0;
        result.op       = OP_ERROR;
        result.red      = '0;
        result.green    = '0;
        result.blue     = '0;
      end
    end else if ((kind != KIND_FILL) && (pos < POS_WIDTH)) begin
      // Coordinate header bytes.
      if (pos == POS_X) begin
        start_x_next = data_byte;
      end else begin
        start_y_next = data_byte;
      end
      pos_next = pos + 3'd1;
    end else if ((kind == KIND_RECT || kind == KIND_CONTIG) && (pos < POS_PIXEL)) begin
      // Size header bytes; an empty contiguous rectangle ends here.
      if (pos == POS_WIDTH) begin
        held_width_next = data_byte;
        pos_next        = pos + 3'd1;
      end else begin
        held_height_next = data_byte;
        if (kind == KIND_CONTIG && (held_width == '0 || data_byte == '0)) begin
          kind_next = KIND_IDLE;
          pos_next  = POS_X;
        end else begin
          pos_next = pos + 3'd1;
        end
      end
    end else if (colour_index == COLOUR_RED) begin
      held_red_next = data_byte;
      pos_next      = pos + 3'd1;
    end else if (colour_index == COLOUR_GREEN) begin
      held_green_next = data_byte;
      pos_next        = pos + 3'd1;
    end else begin
      // Blue byte completes a color triple and yields a result.
      has_result = 1'b1;
      kind_next  = KIND_IDLE;
      pos_next   = POS_X;
      unique case (kind)
        KIND_FILL: begin
          result.op = OP_FILL;
        end
        KIND_PIXEL: begin
          result.op    = OP_PIXEL;
          result.pos_x = {1'b0, start_x};
          result.pos_y = {1'b0, start_y};
        end
        KIND_RECT: begin
          result.op          = OP_RECT;
          result.pos_x       = {1'b0, start_x};
          result.pos_y       = {1'b0, start_y};
          result.rect_width  = held_width;
          result.rect_height = held_height;
        end
        default: begin
          result.op           = OP_PIXEL;
          result.pos_x        = {1'b0, start_x} + {1'b0, column_count};
          result.pos_y        = {1'b0, start_y} + {1'b0, row_count};
          result.command_done = last_pixel;
          if (!last_pixel) begin
            kind_next = kind;
            pos_next  = POS_PIXEL;
            if (last_col) begin
              column_count_next = '0;
              row_count_next    = row_plus[7:0];
            end else begin
              column_count_next = column_plus[7:0];
            end
          end
        end
      endcase
    end
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind         <= KIND_IDLE;
      pos          <= POS_X;
      start_x      <= '0;
      start_y      <= '0;
      held_width   <= '0;
      held_height  <= '0;
      held_red     <= '0;
      held_green   <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      kind         <= kind_next;
      pos          <= pos_next;
      start_x      <= start_x_next;
      start_y      <= start_y_next;
      held_width   <= held_width_next;
      held_height  <= held_height_next;
      held_red     <= held_red_next;
      held_green   <= held_green_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

FILE: sv/pixel_command_stream_parser.sv
// Top level of the pixel command stream parser: input register, decode, result register.
// A completing byte passes through the input register; its result is then captured in the result register.
// Throughput: one byte per cycle; the input register holds a byte only while a result
// is waiting in the output register and that byte would produce another result.
// Reset (rst, synchronous, active high) returns the parser to idle, awaiting a kind byte,
// and empties both registers.
module pixel_command_stream_parser
  import pcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] op,
  output logic [8:0] pos_x,
  output logic [8:0] pos_y,
  output logic [7:0] rect_width,
  output logic [7:0] rect_height,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       command_done
);

  logic         held_valid;
  logic [7:0]   held_byte;
  logic         has_result;
  logic         advance;
  pcsp_result_t result;
  pcsp_result_t out_reg;

  pcsp_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (held_byte),
    .has_result (has_result),
    .result     (result)
  );

  // A held byte is processed unless its result would overwrite a stalled one.
  assign advance  = held_valid && (!has_result || !out_valid || !out_stall);
  assign in_stall = held_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= data_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_reg <= result;
    end
  end

  assign op           = out_reg.op;
  assign pos_x        = out_reg.pos_x;
  assign pos_y        = out_reg.pos_y;
  assign rect_width   = out_reg.rect_width;
  assign rect_height  = out_reg.rect_height;
  assign red          = out_reg.red;
  assign green        = out_reg.green;
  assign blue         = out_reg.blue;
  assign command_done = out_reg.command_done;

endmodule

FILE: tb/tb_pixel_command_stream_parser.sv
// Self-checking testbench for the pixel command stream parser.
`timescale 1ns / 1ps

module tb_pixel_command_stream_parser
  import pcsp_pkg::*;
();

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_BYTES  = 1150;
  localparam int HOLD_TRIGGER  = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;

  // One row of the directed table: a stream byte and, where it is obvious, its command.
  typedef struct packed {
    logic [7:0]   value;
    logic         fixed;
    pcsp_result_t result;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] op;
  logic [8:0] pos_x;
  logic [8:0] pos_y;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       command_done;

  // Commands still owed by the parser, oldest first.
  pcsp_result_t pending_commands[$];
  stim_row_t    directed_rows[$];
  logic [7:0]   random_bytes[$];

  int mismatch_count = 0;
  int bytes_accepted = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit held_off = 1'b0;

  // Parser state mirrored by the testbench.
  logic [2:0]  kind_now = KIND_IDLE;
  logic [2:0]  field_index = POS_X;
  logic [7:0]  org_x = 8'd0;
  logic [7:0]  org_y = 8'd0;
  logic [7:0]  span_w = 8'd0;
  logic [7:0]  span_h = 8'd0;
  logic [15:0] colour_rg = 16'd0;
  logic [7:0]  col_at = 8'd0;
  logic [7:0]  row_at = 8'd0;

  pcsp_result_t want_cmd;
  pcsp_result_t seen_cmd;

  pixel_command_stream_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .command_done (command_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic pcsp_result_t make_cmd(input logic [1:0] c_op, input logic [8:0] x,
                                            input logic [8:0] y, input logic [7:0] w,
                                            input logic [7:0] h, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic done);
    return {c_op, x, y, w, h, r, g, b, done};
  endfunction

  function automatic stim_row_t row(input logic [7:0] value, input logic fixed,
                                    input pcsp_result_t result);
    return {value, fixed, result};
  endfunction

  // Queue appends for the directed table, the random stream and the owed commands.
  function automatic void add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    random_bytes = {random_bytes, b};
  endfunction

  function automatic void owe_cmd(input pcsp_result_t c);
    pending_commands = {pending_commands, c};
  endfunction

  // Advances the mirrored parser by one stream byte and returns the command it completes.
  task automatic decode_stream_byte(input logic [7:0] b, output bit produced,
                                    output pcsp_result_t cmd);
    logic [2:0] colour_idx;
    logic       last_col;
    logic       finished;
    produced = 1'b0;
    cmd = '0;
    finished = 1'b0;
    if (kind_now == KIND_IDLE) begin
      if (b >= {5'd0, KIND_FILL} && b <= {5'd0, KIND_CONTIG}) begin
        kind_now = b[2:0];
        field_index = POS_X;
        col_at = 8'd0;
        row_at = 8'd0;
      end else begin
        // An unknown kind byte reports an error at once and clears the color.
        colour_rg = 16'd0;
        produced = 1'b1;
        cmd = make_cmd(OP_ERROR, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      end
    end else if (kind_now != KIND_FILL && field_index < POS_PIXEL &&
                 !(kind_now == KIND_PIXEL && field_index >= POS_WIDTH)) begin
      // Header bytes: x, y, then width and height for rectangles.
      case (field_index)
        POS_X:     org_x = b;
        POS_Y:     org_y = b;
        POS_WIDTH: span_w = b;
        default:   span_h = b;
      endcase
      if (field_index == POS_HEIGHT && kind_now == KIND_CONTIG &&
          (span_w == 8'd0 || span_h == 8'd0)) begin
        kind_now = KIND_IDLE;
        field_index = POS_X;
      end else begin
        field_index = field_index + 3'd1;
      end
    end else begin
      // Color bytes; the blue byte completes a command or a rectangle pixel.
      case (kind_now)
        KIND_FILL:  colour_idx = field_index;
        KIND_PIXEL: colour_idx = field_index - POS_WIDTH;
        default:    colour_idx = field_index - POS_PIXEL;
      endcase
      if (colour_idx == COLOUR_RED) begin
        colour_rg[15:8] = b;
        field_index = field_index + 3'd1;
      end else if (colour_idx == COLOUR_GREEN) begin
        colour_rg[7:0] = b;
        field_index = field_index + 3'd1;
      end else begin
        produced = 1'b1;
        finished = 1'b1;
        case (kind_now)
          KIND_FILL: begin
            cmd = make_cmd(OP_FILL, 9'd0, 9'd0, 8'd0, 8'd0, colour_rg[15:8], colour_rg[7:0],
                           b, 1'b1);
          end
          KIND_PIXEL: begin
            cmd = make_cmd(OP_PIXEL, {1'b0, org_x}, {1'b0, org_y}, 8'd0, 8'd0,
                           colour_rg[15:8], colour_rg[7:0], b, 1'b1);
          end
          KIND_RECT: begin
            cmd = make_cmd(OP_RECT, {1'b0, org_x}, {1'b0, org_y}, span_w, span_h,
                           colour_rg[15:8], colour_rg[7:0], b, 1'b1);
          end
          default: begin
            // Contiguous rectangle pixels walk row-major, x fastest.
            last_col = ({1'b0, col_at} + 9'd1) >= {1'b0, span_w};
            finished = last_col && (({1'b0, row_at} + 9'd1) >= {1'b0, span_h});
            cmd = make_cmd(OP_PIXEL, {1'b0, org_x} + {1'b0, col_at},
                           {1'b0, org_y} + {1'b0, row_at}, 8'd0, 8'd0,
                           colour_rg[15:8], colour_rg[7:0], b, finished);
            if (!finished) begin
              if (last_col) begin
                col_at = 8'd0;
                row_at = row_at + 8'd1;
              end else begin
                col_at = col_at + 8'd1;
              end
              field_index = POS_PIXEL;
            end
          end
        endcase
        if (finished) begin
          kind_now = KIND_IDLE;
          field_index = POS_X;
        end
      end
    end
  endtask

  // Offers one byte, in bursts with random gaps, and records what it should produce.
  task automatic transmit(input logic [7:0] b, input logic fixed, input pcsp_result_t lit);
    bit           produced;
    pcsp_result_t predicted;
    int           gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_accepted++;
    decode_stream_byte(b, produced, predicted);
    if (fixed) begin
      owe_cmd(lit);
    end else if (produced) begin
      owe_cmd(predicted);
    end
  endtask

  // Stops offering bytes until every owed command has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_commands.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Main stimulus: reset, directed table, then random command streams.
  initial begin : stimulus
    int          pick;
    int          w;
    int          h;
    int          x;
    int          y;
    bit          big_done;
    logic [7:0]  kind_byte;
    big_done = 1'b0;

    // Unknown kinds at both ends of the byte range.
    add_row(row(8'h00, 1'b1, make_cmd(OP_ERROR, 9'd0, 9'd0, 8'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 1'b1)));
    add_row(row(8'hFF, 1'b1, make_cmd(OP_ERROR, 9'd0, 9'd0, 8'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 1'b1)));
    // Fill with extreme color bytes.
    add_row(row({5'd0, KIND_FILL}, 1'b0, '0));
    add_row(row(8'hFF, 1'b0, '0));
    add_row(row(8'h00, 1'b0, '0));
    add_row(row(8'hFF, 1'b1, make_cmd(OP_FILL, 9'd0, 9'd0, 8'd0, 8'd0,
                                      8'hFF, 8'h00, 8'hFF, 1'b1)));
    // Pixel at the far column.
    add_row(row({5'd0, KIND_PIXEL}, 1'b0, '0));
    add_row(row(8'hFF, 1'b0, '0));
    add_row(row(8'h00, 1'b0, '0));
    add_row(row(8'h00, 1'b0, '0));
    add_row(row(8'hFF, 1'b0, '0));
    add_row(row(8'h00, 1'b1, make_cmd(OP_PIXEL, 9'd255, 9'd0, 8'd0, 8'd0,
                                      8'h00, 8'hFF, 8'h00, 1'b1)));
    // Solid rectangle with zero width is still reported.
    add_row(row({5'd0, KIND_RECT}, 1'b0, '0));
    add_row(row(8'h00, 1'b0, '0));
    add_row(row(8'hFF, 1'b0, '0));
    add_row(row(8'h00, 1'b0, '0));
    add_row(row(8'hFF, 1'b0, '0));
    add_row(row(8'hAA, 1'b0, '0));
    add_row(row(8'h55, 1'b0, '0));
    add_row(row(8'h80, 1'b1, make_cmd(OP_RECT, 9'd0, 9'd255, 8'd0, 8'hFF,
                                      8'hAA, 8'h55, 8'h80, 1'b1)));
    // Empty contiguous rectangle ends after its height byte.
    add_row(row({5'd0, KIND_CONTIG}, 1'b0, '0));
    add_row(row(8'h10, 1'b0, '0));
    add_row(row(8'h20, 1'b0, '0));
    add_row(row(8'h00, 1'b0, '0));
    add_row(row(8'h05, 1'b0, '0));

    // Random part: mostly well-formed commands with random content, some noise.
    while (random_bytes.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        pick = $urandom_range(0, 251);
        kind_byte = (pick == 0) ? 8'd0 : 8'(pick + 4);
        add_byte(kind_byte);
      end else if (pick < 10) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 25) begin
        add_byte({5'd0, KIND_FILL});
        repeat (3) add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        add_byte({5'd0, KIND_PIXEL});
        repeat (5) add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 62) begin
        add_byte({5'd0, KIND_RECT});
        repeat (2) add_byte(8'($urandom_range(0, 255)));
        repeat (2) add_byte(($urandom_range(0, 7) == 0) ? 8'd0 :
                            8'($urandom_range(0, 255)));
        repeat (3) add_byte(8'($urandom_range(0, 255)));
      end else begin
        // One long strip at the far corner reaches the largest coordinates.
        if (!big_done && random_bytes.size() > 300) begin
          big_done = 1'b1;
          if ($urandom_range(0, 1) == 1) begin
            w = 255;
            h = 1;
          end else begin
            w = 1;
            h = 255;
          end
          x = $urandom_range(250, 255);
          y = $urandom_range(250, 255);
        end else begin
          w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
          h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        add_byte({5'd0, KIND_CONTIG});
        add_byte(8'(x));
        add_byte(8'(y));
        add_byte(8'(w));
        add_byte(8'(h));
        if (w != 0 && h != 0) begin
          repeat (w * h * 3) add_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      transmit(directed_rows[i].value, directed_rows[i].fixed, directed_rows[i].result);
    end
    drain_results();

    foreach (random_bytes[i]) begin
      if (i == random_bytes.size() / 2) begin
        drain_results();
      end
      transmit(random_bytes[i], 1'b0, '0);
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stall patterns in segments, plus one long hold-off while bytes keep coming.
  initial begin : receiver
    int seg_len;
    int mode;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && bytes_accepted >= HOLD_TRIGGER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg_len = $urandom_range(10, 60);
      mode = $urandom_range(0, 2);
      repeat (seg_len) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest owed command.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_cmd = {op, pos_x, pos_y, rect_width, rect_height, red, green, blue, command_done};
      if (pending_commands.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual op %0d x %0d y %0d",
                 $time, seen_cmd.op, seen_cmd.pos_x, seen_cmd.pos_y);
        mismatch_count++;
      end else begin
        want_cmd = pending_commands.pop_front();
        check_field("op", 9'(want_cmd.op), 9'(seen_cmd.op));
        check_field("pos_x", want_cmd.pos_x, seen_cmd.pos_x);
        check_field("pos_y", want_cmd.pos_y, seen_cmd.pos_y);
        check_field("rect_width", 9'(want_cmd.rect_width), 9'(seen_cmd.rect_width));
        check_field("rect_height", 9'(want_cmd.rect_height), 9'(seen_cmd.rect_height));
        check_field("red", 9'(want_cmd.red), 9'(seen_cmd.red));
        check_field("green", 9'(want_cmd.green), 9'(seen_cmd.green));
        check_field("blue", 9'(want_cmd.blue), 9'(seen_cmd.blue));
        check_field("command_done", 9'(want_cmd.command_done), 9'(seen_cmd.command_done));
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
